[hdl/ffsa_pkg.sv]
// package: types, constants and codes shared by the segment allocator
`default_nettype none
package ffsa_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int HOLE_W       = 6;
    localparam logic [31:0] POOL_RESET  = 32'd65536;
    localparam logic [15:0] SLACK_RESET = 16'd64;
    localparam logic [31:0] ADDR_MASK   = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_COMPACT = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOSEG   = 2'd2
    } status_t;

    localparam logic KIND_FINAL = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;

    localparam logic [0:0] REG_POOL  = 1'd0;
    localparam logic [0:0] REG_SLACK = 1'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIT,
        S_SPLIT,
        S_GRANT,
        S_FIND,
        S_MERGE,
        S_CMP,
        S_CMP_TAIL,
        S_CMP_DONE,
        S_STATS,
        S_OUT,
        S_MOVE_OUT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT,
        CMD_FIT_STEP,
        CMD_SPLIT,
        CMD_GRANT,
        CMD_FIND_STEP,
        CMD_FREE_MARK,
        CMD_MERGE_STEP,
        CMD_CMP_START,
        CMD_CMP_STEP,
        CMD_CMP_TAIL,
        CMD_STATS_START,
        CMD_STATS_STEP
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic fit_hit;
        logic find_hit;
        logic merge_end;
        logic move_pending;
        logic do_split;
        logic retried;
    } dp_status_t;

    typedef struct packed {
        logic    [0:0]  kind;
        status_t        status;
        logic    [31:0] seg_start;
        logic    [31:0] move_source;
        logic    [31:0] move_length;
        logic    [31:0] bytes_free;
        logic    [31:0] largest_hole;
        logic    [HOLE_W-1:0] hole_count;
        logic           last;
    } result_t;
endpackage
`default_nettype wire

[hdl/ffsa_if.sv]
// interfaces: request and result channels
`default_nettype none
interface ffsa_req_if;
    import ffsa_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] req_size;
    logic [31:0] target_offset;
    modport source (output valid, action, req_size, target_offset, input ready);
    modport sink (input valid, action, req_size, target_offset, output ready);
endinterface

interface ffsa_res_if;
    import ffsa_pkg::*;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [1:0]  status;
    logic [31:0] seg_start;
    logic [31:0] move_source;
    logic [31:0] move_length;
    logic [31:0] bytes_free;
    logic [31:0] largest_hole;
    logic [5:0]  hole_count;
    logic        last;
    modport source (output valid, kind, status, seg_start, move_source, move_length,
        bytes_free, largest_hole, hole_count, last, input ready);
    modport sink (input valid, kind, status, seg_start, move_source, move_length,
        bytes_free, largest_hole, hole_count, last, output ready);
endinterface
`default_nettype wire

[hdl/ffsa_datapath.sv]
// datapath: segment table, scan index, compaction and statistics
`default_nettype none
module ffsa_datapath
    import ffsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [31:0] in_req_size,
    input  wire logic [31:0] in_target,
    input  wire logic [31:0] pool_bytes,
    input  wire logic [15:0] split_slack,
    output dp_status_t       sts,
    output result_t          res
);
    logic [31:0] start_reg [MAX_SEGMENTS];
    logic [31:0] len_reg   [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] busy_reg;
    logic [CNT_W-1:0] total_reg;
    logic [31:0] used_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             scan_done_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [31:0]      cur_reg;
    logic [31:0]      req_reg;
    logic [31:0]      tgt_reg;
    logic             retried_reg;
    logic             status_nospace_reg;
    logic             status_noseg_reg;
    logic [31:0]      ans_start_reg;
    logic [31:0]      ans_len_reg;
    logic             mv_reg;
    logic [31:0]      mv_src_reg;
    logic [31:0]      mv_dst_reg;
    logic [31:0]      mv_len_reg;
    logic [31:0]      big_reg;
    logic [HOLE_W-1:0] holes_reg;

    logic [CNT_W-1:0] idx_ext;
    logic             in_range;
    logic             last_idx;
    logic [32:0]      need;
    logic             split_ok;

    assign idx_ext  = CNT_W'(idx_reg);
    assign in_range = (idx_ext < total_reg) && !scan_done_reg;
    assign last_idx = (idx_reg == IDX_W'(MAX_SEGMENTS - 1));
    assign need     = {1'b0, req_reg} + {17'd0, split_slack};
    assign split_ok = ({1'b0, len_reg[idx_reg]} > need) &&
        (total_reg < CNT_W'(MAX_SEGMENTS));

    always_comb
    begin
        sts.scan_end     = !in_range;
        sts.fit_hit      = in_range && !busy_reg[idx_reg] && len_reg[idx_reg] >= req_reg;
        sts.find_hit     = in_range && busy_reg[idx_reg] && start_reg[idx_reg] == tgt_reg;
        sts.merge_end    = !(idx_ext + CNT_W'(1) < total_reg);
        sts.move_pending = mv_reg;
        sts.do_split     = split_ok;
        sts.retried      = retried_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= '0;
            total_reg <= CNT_W'(1);
            used_reg  <= '0;
            mv_reg    <= 1'b0;
            retried_reg <= 1'b0;
            idx_reg   <= '0;
            scan_done_reg <= 1'b0;
            wr_reg    <= '0;
            cur_reg   <= '0;
            req_reg   <= '0;
            tgt_reg   <= '0;
            status_nospace_reg <= 1'b0;
            status_noseg_reg <= 1'b0;
            ans_start_reg <= '0;
            ans_len_reg <= '0;
            mv_src_reg <= '0;
            mv_dst_reg <= '0;
            mv_len_reg <= '0;
            big_reg   <= '0;
            holes_reg <= '0;
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i]   <= (i == 0) ? (POOL_RESET & ADDR_MASK) : '0;
            end
        end
        else
        begin
            unique case (cmd)
                CMD_NONE: ;
                CMD_LOAD:
                begin
                    req_reg <= in_req_size & ADDR_MASK;
                    tgt_reg <= in_target;
                    idx_reg <= '0;
                    scan_done_reg <= 1'b0;
                    retried_reg <= 1'b0;
                    status_nospace_reg <= 1'b0;
                    status_noseg_reg <= 1'b0;
                    ans_start_reg <= '0;
                    ans_len_reg <= '0;
                end
                CMD_INIT:
                begin
                    busy_reg  <= '0;
                    total_reg <= CNT_W'(1);
                    used_reg  <= '0;
                    for (int i = 0; i < MAX_SEGMENTS; i++)
                    begin
                        start_reg[i] <= '0;
                        len_reg[i]   <= (i == 0) ? pool_bytes : '0;
                    end
                end
                CMD_FIT_STEP:
                begin
                    if (!sts.fit_hit && in_range)
                    begin
                        if (last_idx)
                            scan_done_reg <= 1'b1;
                        else
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                    if (!in_range && retried_reg)
                        status_nospace_reg <= 1'b1;
                end
                CMD_SPLIT:
                begin
                    for (int j = 1; j < MAX_SEGMENTS; j++)
                    begin
                        if (j > int'(idx_reg) + 1 && j <= int'(total_reg))
                        begin
                            start_reg[j] <= start_reg[j-1];
                            len_reg[j]   <= len_reg[j-1];
                            busy_reg[j]  <= busy_reg[j-1];
                        end
                        else if (j == int'(idx_reg) + 1)
                        begin
                            start_reg[j] <= start_reg[idx_reg] + req_reg;
                            len_reg[j]   <= len_reg[idx_reg] - req_reg;
                            busy_reg[j]  <= 1'b0;
                        end
                    end
                    len_reg[idx_reg] <= req_reg;
                    total_reg <= total_reg + CNT_W'(1);
                end
                CMD_GRANT:
                begin
                    busy_reg[idx_reg] <= 1'b1;
                    used_reg <= used_reg + len_reg[idx_reg];
                    ans_start_reg <= start_reg[idx_reg];
                    ans_len_reg <= len_reg[idx_reg];
                end
                CMD_FIND_STEP:
                begin
                    if (!in_range)
                        status_noseg_reg <= 1'b1;
                    else if (!sts.find_hit)
                    begin
                        if (last_idx)
                            scan_done_reg <= 1'b1;
                        else
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                CMD_FREE_MARK:
                begin
                    busy_reg[idx_reg] <= 1'b0;
                    used_reg <= (used_reg >= len_reg[idx_reg]) ?
                        used_reg - len_reg[idx_reg] : '0;
                    ans_start_reg <= start_reg[idx_reg];
                    ans_len_reg <= len_reg[idx_reg];
                    idx_reg <= '0;
                end
                CMD_MERGE_STEP:
                begin
                    if (!busy_reg[idx_reg] && !busy_reg[idx_reg + IDX_W'(1)])
                    begin
                        len_reg[idx_reg] <= len_reg[idx_reg] + len_reg[idx_reg + IDX_W'(1)];
                        for (int j = 1; j < MAX_SEGMENTS - 1; j++)
                        begin
                            if (j > int'(idx_reg) && j + 1 < int'(total_reg))
                            begin
                                start_reg[j] <= start_reg[j+1];
                                len_reg[j]   <= len_reg[j+1];
                                busy_reg[j]  <= busy_reg[j+1];
                            end
                        end
                        start_reg[total_reg[IDX_W-1:0] - IDX_W'(1)] <= '0;
                        len_reg[total_reg[IDX_W-1:0] - IDX_W'(1)]   <= '0;
                        busy_reg[total_reg[IDX_W-1:0] - IDX_W'(1)]  <= 1'b0;
                        total_reg <= total_reg - CNT_W'(1);
                    end
                    else
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                CMD_CMP_START:
                begin
                    idx_reg <= '0;
                    scan_done_reg <= 1'b0;
                    wr_reg  <= '0;
                    cur_reg <= '0;
                end
                CMD_CMP_STEP:
                begin
                    // read index never falls behind the write index, so in-place packing is safe
                    mv_reg <= in_range && busy_reg[idx_reg] &&
                        (start_reg[idx_reg] != cur_reg);
                    if (in_range)
                    begin
                        if (busy_reg[idx_reg])
                        begin
                            if (start_reg[idx_reg] != cur_reg)
                            begin
                                mv_src_reg <= start_reg[idx_reg];
                                mv_dst_reg <= cur_reg;
                                mv_len_reg <= len_reg[idx_reg];
                            end
                            start_reg[wr_reg[IDX_W-1:0]] <= cur_reg;
                            len_reg[wr_reg[IDX_W-1:0]]   <= len_reg[idx_reg];
                            busy_reg[wr_reg[IDX_W-1:0]]  <= 1'b1;
                            cur_reg <= cur_reg + len_reg[idx_reg];
                            wr_reg  <= wr_reg + CNT_W'(1);
                        end
                        if (idx_ext + CNT_W'(1) < CNT_W'(MAX_SEGMENTS))
                            idx_reg <= idx_reg + IDX_W'(1);
                        else
                            total_reg <= '0;
                    end
                end
                CMD_CMP_TAIL:
                begin
                    for (int i = 0; i < MAX_SEGMENTS; i++)
                    begin
                        if (CNT_W'(i) >= wr_reg)
                        begin
                            start_reg[i] <= '0;
                            len_reg[i]   <= '0;
                            busy_reg[i]  <= 1'b0;
                        end
                    end
                    if (cur_reg < pool_bytes && wr_reg < CNT_W'(MAX_SEGMENTS))
                    begin
                        start_reg[wr_reg[IDX_W-1:0]] <= cur_reg;
                        len_reg[wr_reg[IDX_W-1:0]]   <= pool_bytes - cur_reg;
                        total_reg <= wr_reg + CNT_W'(1);
                    end
                    else
                        total_reg <= wr_reg;
                    used_reg <= cur_reg;
                    idx_reg <= '0;
                    scan_done_reg <= 1'b0;
                    mv_reg <= 1'b0;
                    retried_reg <= 1'b1;
                end
                CMD_STATS_START:
                begin
                    idx_reg   <= '0;
                    scan_done_reg <= 1'b0;
                    big_reg   <= '0;
                    holes_reg <= '0;
                end
                CMD_STATS_STEP:
                begin
                    if (in_range)
                    begin
                        if (!busy_reg[idx_reg])
                        begin
                            holes_reg <= holes_reg + HOLE_W'(1);
                            if (len_reg[idx_reg] > big_reg)
                                big_reg <= len_reg[idx_reg];
                        end
                        if (last_idx)
                            scan_done_reg <= 1'b1;
                        else
                            idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    logic ok_ans;
    assign ok_ans = !status_nospace_reg && !status_noseg_reg;

    always_comb
    begin
        res.kind         = KIND_FINAL;
        res.status       = status_nospace_reg ? ST_NOSPACE :
                           status_noseg_reg ? ST_NOSEG : ST_OK;
        res.seg_start    = ok_ans ? ans_start_reg : '0;
        res.move_source  = '0;
        res.move_length  = ok_ans ? ans_len_reg : '0;
        res.bytes_free   = (pool_bytes >= used_reg) ? pool_bytes - used_reg : '0;
        res.largest_hole = big_reg;
        res.hole_count   = holes_reg;
        res.last         = 1'b1;
        if (mv_reg)
        begin
            res.kind         = KIND_MOVE;
            res.status       = ST_OK;
            res.seg_start    = mv_dst_reg;
            res.move_source  = mv_src_reg;
            res.move_length  = mv_len_reg;
            res.bytes_free   = '0;
            res.largest_hole = '0;
            res.hole_count   = '0;
            res.last         = 1'b0;
        end
    end
endmodule
`default_nettype wire

[hdl/ffsa_ctrl.sv]
// controller: sequencing of scans, splits, merges and compaction
`default_nettype none
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_action,
    output logic            in_ready,
    input  wire dp_status_t sts,
    input  wire logic       out_free,
    output logic            out_load,
    output logic            out_move,
    output cmd_t            cmd
);
    state_t state_reg, state_next;
    logic [1:0] act_reg, act_next;
    logic stats_prev_reg, stats_prev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_ALLOC;
            stats_prev_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            stats_prev_reg <= stats_prev_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        stats_prev_next = 1'b0;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        out_move   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    act_next = in_action;
                    case (in_action)
                        ACT_ALLOC:   state_next = S_FIT;
                        ACT_FREE:    state_next = S_FIND;
                        ACT_COMPACT: state_next = S_CMP;
                        default:     state_next = S_STATS;
                    endcase
                end
            end
            S_FIT:
            begin
                cmd = CMD_FIT_STEP;
                if (sts.fit_hit)
                    state_next = sts.do_split ? S_SPLIT : S_GRANT;
                else if (sts.scan_end)
                    state_next = sts.retried ? S_STATS : S_CMP;
            end
            S_SPLIT:
            begin
                cmd = CMD_SPLIT;
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                cmd = CMD_GRANT;
                state_next = S_STATS;
            end
            S_FIND:
            begin
                cmd = CMD_FIND_STEP;
                if (sts.find_hit)
                    state_next = S_MERGE;
                else if (sts.scan_end)
                    state_next = S_STATS;
            end
            S_MERGE:
            begin
                if (!stats_prev_reg)
                begin
                    cmd = CMD_FREE_MARK;
                    stats_prev_next = 1'b1;
                end
                else if (sts.merge_end)
                    state_next = S_STATS;
                else
                begin
                    cmd = CMD_MERGE_STEP;
                    stats_prev_next = 1'b1;
                end
            end
            S_CMP:
            begin
                if (!stats_prev_reg)
                begin
                    cmd = CMD_CMP_START;
                    stats_prev_next = 1'b1;
                end
                else
                begin
                    stats_prev_next = 1'b1;
                    if (sts.scan_end)
                        state_next = S_CMP_TAIL;
                    else
                    begin
                        cmd = CMD_CMP_STEP;
                        state_next = S_MOVE_OUT;
                    end
                end
            end
            S_MOVE_OUT:
            begin
                stats_prev_next = 1'b1;
                if (!sts.move_pending)
                    state_next = S_CMP;
                else if (out_free)
                begin
                    out_move = 1'b1;
                    state_next = S_CMP;
                end
                else
                    state_next = S_MOVE_OUT;
            end
            S_CMP_TAIL:
            begin
                cmd = CMD_CMP_TAIL;
                state_next = S_CMP_DONE;
            end
            S_CMP_DONE:
            begin
                state_next = (act_reg == ACT_ALLOC) ? S_FIT : S_STATS;
            end
            S_STATS:
            begin
                if (!stats_prev_reg)
                begin
                    if (act_reg == ACT_CLEAR)
                        cmd = CMD_INIT;
                    stats_prev_next = 1'b1;
                end
                else
                begin
                    if (act_reg == ACT_CLEAR || sts.scan_end)
                    begin
                    end
                    cmd = CMD_STATS_START;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!sts.scan_end)
                    cmd = CMD_STATS_STEP;
                else if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hdl/first_fit_segment_allocator.sv]
// top level: first-fit segment allocator with compaction
// allocate scans the table to the first fit and grants it, with a split step before the grant
// free scans for the segment and then merges free neighbours; compact packs the live segments
// an allocate that misses compacts the table and retries the scan once
// throughput: one request at a time, set by the table scans; each stalled word adds its stall
// rst_n asynchronous active low: pool of 65536 bytes, one free segment, slack 64
`default_nettype none
module first_fit_segment_allocator
    import ffsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffsa_req_if.sink         req,
    ffsa_res_if.source       res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic [31:0] pool_reg;
    logic [15:0] slack_reg;
    logic        wr_en;
    logic        pool_wr;
    logic [31:0] pool_now;
    cmd_t        cmd;
    cmd_t        cmd_dp;
    dp_status_t  sts;
    result_t     dp_res;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        out_load;
    logic        out_move;
    logic        out_free;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign pool_wr = wr_en && paddr[2] == REG_POOL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= POOL_RESET & ADDR_MASK;
            slack_reg <= SLACK_RESET;
        end
        else if (wr_en && paddr[1:0] == 2'd0)
        begin
            unique case (paddr[2])
                REG_POOL:  pool_reg  <= pwdata & ADDR_MASK;
                REG_SLACK: slack_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_POOL:  prdata = pool_reg;
            REG_SLACK: prdata = {16'd0, slack_reg};
            default:   prdata = '0;
        endcase
    end

    assign cmd_dp   = (pool_wr && paddr[1:0] == 2'd0) ? CMD_INIT : cmd;
    assign pool_now = (pool_wr && paddr[1:0] == 2'd0) ? (pwdata & ADDR_MASK) : pool_reg;

    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_action (req.action),
        .in_ready  (req.ready),
        .sts       (sts),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_move  (out_move),
        .cmd       (cmd)
    );

    ffsa_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_dp),
        .in_req_size (req.req_size),
        .in_target   (req.target_offset),
        .pool_bytes  (pool_now),
        .split_slack (slack_reg),
        .sts         (sts),
        .res         (dp_res)
    );

    assign out_free = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load || out_move)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load || out_move)
            out_reg <= dp_res;
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.status       = out_reg.status;
    assign res.seg_start    = out_reg.seg_start;
    assign res.move_source  = out_reg.move_source;
    assign res.move_length  = out_reg.move_length;
    assign res.bytes_free   = out_reg.bytes_free;
    assign res.largest_hole = out_reg.largest_hole;
    assign res.hole_count   = out_reg.hole_count;
    assign res.last         = out_reg.last;
endmodule
`default_nettype wire

[hdl/ffsa_checker.sv]
// checker: port-level properties of the segment allocator
`default_nettype none
module ffsa_assertions
    import ffsa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ffsa_req_if.sink   req,
    ffsa_res_if.source res
);
    a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_MOVE |-> !res.last)
        else $error("move word marked last");
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind == KIND_FINAL |-> res.last)
        else $error("final word not marked last");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.seg_start))
        else $error("result dropped under stall");
endmodule

bind first_fit_segment_allocator ffsa_assertions u_ffsa_assertions (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
);
`default_nettype wire

[sim/ffsa_checker.sv]
// checker: watches request, result and register write channels, predicts the allocator and compares words
module ffsa_checker
    import ffsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffsa_req_if.sink         req,
    ffsa_res_if.sink         res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending
);
    logic [31:0] pool;
    logic [15:0] slack;
    logic [31:0] seg_off [MAX_SEGMENTS];
    logic [31:0] seg_len [MAX_SEGMENTS];
    logic        seg_busy [MAX_SEGMENTS];
    int          seg_n;
    logic [31:0] used;
    result_t     expected_words [$];

    function automatic void table_clear();
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            seg_off[i] = '0;
            seg_len[i] = '0;
            seg_busy[i] = 1'b0;
        end
        seg_len[0] = pool;
        seg_n = 1;
        used = '0;
    endfunction

    function automatic void push_word(logic kind, status_t st, logic [31:0] start,
        logic [31:0] src, logic [31:0] len, logic fin);
        result_t w;
        logic [31:0] big;
        int holes;
        big = '0;
        holes = 0;
        w = '0;
        w.kind = kind;
        w.status = st;
        w.seg_start = start;
        w.move_source = src;
        w.move_length = len;
        w.last = fin;
        if (fin)
        begin
            for (int i = 0; i < seg_n; i++)
                if (!seg_busy[i])
                begin
                    holes++;
                    if (seg_len[i] > big)
                        big = seg_len[i];
                end
            w.bytes_free = (pool >= used) ? pool - used : '0;
            w.largest_hole = big;
            w.hole_count = holes[HOLE_W-1:0];
        end
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void pack_pool();
        logic [31:0] ns [MAX_SEGMENTS];
        logic [31:0] nl [MAX_SEGMENTS];
        logic [31:0] cur;
        int n;
        cur = '0;
        n = 0;
        for (int i = 0; i < seg_n; i++)
        begin
            if (seg_busy[i])
            begin
                if (seg_off[i] != cur)
                    push_word(KIND_MOVE, ST_OK, cur, seg_off[i], seg_len[i], 1'b0);
                ns[n] = cur;
                nl[n] = seg_len[i];
                cur = cur + seg_len[i];
                n++;
            end
        end
        for (int i = 0; i < MAX_SEGMENTS; i++)
            seg_busy[i] = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            seg_off[i] = ns[i];
            seg_len[i] = nl[i];
            seg_busy[i] = 1'b1;
        end
        if (cur < pool && n < MAX_SEGMENTS)
        begin
            seg_off[n] = cur;
            seg_len[n] = pool - cur;
            n++;
        end
        for (int i = n; i < MAX_SEGMENTS; i++)
        begin
            seg_off[i] = '0;
            seg_len[i] = '0;
        end
        seg_n = n;
        used = cur;
    endfunction

    function automatic int first_fit(logic [31:0] sz);
        for (int i = 0; i < seg_n; i++)
            if (!seg_busy[i] && seg_len[i] >= sz)
                return i;
        return -1;
    endfunction

    function automatic void merge_holes();
        int i;
        i = 0;
        while (i + 1 < seg_n)
        begin
            if (!seg_busy[i] && !seg_busy[i+1])
            begin
                seg_len[i] = seg_len[i] + seg_len[i+1];
                for (int j = i + 1; j + 1 < seg_n; j++)
                begin
                    seg_off[j] = seg_off[j+1];
                    seg_len[j] = seg_len[j+1];
                    seg_busy[j] = seg_busy[j+1];
                end
                seg_n--;
                seg_off[seg_n] = '0;
                seg_len[seg_n] = '0;
                seg_busy[seg_n] = 1'b0;
            end
            else
                i++;
        end
    endfunction

    function automatic void predict_request(action_t act, logic [31:0] sz, logic [31:0] tgt);
        int f;
        int i;
        logic [32:0] need;
        logic [31:0] s;
        logic [31:0] l;
        sz = sz & ADDR_MASK;
        case (act)
            ACT_ALLOC:
            begin
                f = first_fit(sz);
                if (f < 0)
                begin
                    pack_pool();
                    f = first_fit(sz);
                end
                if (f < 0)
                    push_word(KIND_FINAL, ST_NOSPACE, '0, '0, '0, 1'b1);
                else
                begin
                    need = {1'b0, sz} + {17'b0, slack};
                    if ({1'b0, seg_len[f]} > need && seg_n < MAX_SEGMENTS)
                    begin
                        for (int j = seg_n; j > f + 1; j--)
                        begin
                            seg_off[j] = seg_off[j-1];
                            seg_len[j] = seg_len[j-1];
                            seg_busy[j] = seg_busy[j-1];
                        end
                        seg_off[f+1] = seg_off[f] + sz;
                        seg_len[f+1] = seg_len[f] - sz;
                        seg_busy[f+1] = 1'b0;
                        seg_len[f] = sz;
                        seg_n++;
                    end
                    seg_busy[f] = 1'b1;
                    used = used + seg_len[f];
                    push_word(KIND_FINAL, ST_OK, seg_off[f], '0, seg_len[f], 1'b1);
                end
            end
            ACT_FREE:
            begin
                for (i = 0; i < seg_n; i++)
                    if (seg_busy[i] && seg_off[i] == tgt)
                        break;
                if (i >= seg_n)
                    push_word(KIND_FINAL, ST_NOSEG, '0, '0, '0, 1'b1);
                else
                begin
                    s = seg_off[i];
                    l = seg_len[i];
                    seg_busy[i] = 1'b0;
                    used = (used >= l) ? used - l : '0;
                    merge_holes();
                    push_word(KIND_FINAL, ST_OK, s, '0, l, 1'b1);
                end
            end
            ACT_COMPACT:
            begin
                pack_pool();
                push_word(KIND_FINAL, ST_OK, '0, '0, '0, 1'b1);
            end
            default:
            begin
                table_clear();
                push_word(KIND_FINAL, ST_OK, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t exp_w;
        if (!rst_n)
        begin
            pool = POOL_RESET & ADDR_MASK;
            slack = SLACK_RESET;
            fail_count = 0;
            expected_words.delete();
            table_clear();
            pending = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got.kind = res.kind;
                got.status = status_t'(res.status);
                got.seg_start = res.seg_start;
                got.move_source = res.move_source;
                got.move_length = res.move_length;
                got.bytes_free = res.bytes_free;
                got.largest_hole = res.largest_hole;
                got.hole_count = res.hole_count;
                got.last = res.last;
                if (expected_words.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h", got);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", exp_w, got);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_request(action_t'(req.action), req.req_size, req.target_offset);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_POOL)
                begin
                    pool = pwdata & ADDR_MASK;
                    table_clear();
                end
                else
                    slack = pwdata[15:0];
            end
            pending = expected_words.size();
        end
    end
endmodule

[sim/first_fit_segment_allocator_tb.sv]
// testbench top: stimulus, register writes and verdict for the segment allocator
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          req_gap;
    int          res_gap;
    logic        calm;
    logic [31:0] live_offsets [$];

    ffsa_req_if req ();
    ffsa_res_if res ();

    first_fit_segment_allocator i_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready));

    ffsa_checker i_checker (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .res(res.sink),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // random receive stalls in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_gap <= 0;
        end
        else if (res_gap > 0)
        begin
            res_gap <= res_gap - 1;
            res.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            res_gap <= $urandom_range(1, 14) - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= 1'b1;
    end

    // record offsets of granted and freed segments so frees mostly hit live segments
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready && res.kind == KIND_FINAL &&
            res.status == ST_OK && res.move_length != 0 && live_offsets.size() < 64)
            live_offsets.insert(live_offsets.size(), res.seg_start);
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(action_t act, logic [31:0] sz, logic [31:0] tgt);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.req_size <= sz;
        req.target_offset <= tgt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4 * MAX_SEGMENTS * 4) @(posedge clk);
        live_offsets.delete();
    endtask

    task automatic random_phase(int count, logic [31:0] pool_sz);
        int pick;
        logic [31:0] sz;
        logic [31:0] tgt;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                case ($urandom_range(0, 3))
                    0: sz = $urandom();
                    1: sz = $urandom_range(0, 16);
                    default: sz = $urandom_range(0, (pool_sz >> 3) + 1);
                endcase
                send_word(ACT_ALLOC, sz, $urandom());
            end
            else if (pick < 88)
            begin
                if (live_offsets.size() > 0 && $urandom_range(0, 4) != 0)
                begin
                    tgt = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
                end
                else
                    tgt = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 64);
                send_word(ACT_FREE, $urandom(), tgt);
            end
            else if (pick < 96)
                send_word(ACT_COMPACT, $urandom(), $urandom());
            else
                send_word(ACT_CLEAR, $urandom(), $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        req.valid <= 1'b0;
        req.action <= ACT_ALLOC;
        req.req_size <= '0;
        req.target_offset <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        send_word(ACT_ALLOC, 32'd0, '0);
        send_word(ACT_ALLOC, 32'd100, '0);
        send_word(ACT_ALLOC, 32'd200, '0);
        send_word(ACT_ALLOC, 32'd300, '0);
        send_word(ACT_FREE, '0, 32'd0);
        send_word(ACT_FREE, '0, 32'd100);
        send_word(ACT_FREE, '0, 32'd100);
        send_word(ACT_FREE, '0, 32'hFFFF_FFFF);
        send_word(ACT_ALLOC, 32'd65000, '0);
        send_word(ACT_ALLOC, 32'hFFFF_FFFF, '0);
        send_word(ACT_COMPACT, '0, '0);
        send_word(ACT_CLEAR, '0, '0);
        send_word(ACT_ALLOC, 32'd65536, '0);
        send_word(ACT_ALLOC, 32'd1, '0);
        send_word(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // small pool, no slack: full table and relocations
        reg_write({REG_POOL, 2'b00}, 32'd4096);
        reg_write({REG_SLACK, 2'b00}, 32'd0);
        for (int n = 0; n < 34; n++)
            send_word(ACT_ALLOC, 32'd16, '0);
        for (int n = 0; n < 16; n++)
            send_word(ACT_FREE, '0, 32'(n * 32));
        send_word(ACT_ALLOC, 32'd3000, '0);
        drain();
        random_phase(120, 32'd4096);
        drain();

        // maximum slack, largest pool
        reg_write({REG_SLACK, 2'b00}, 32'hFFFF);
        reg_write({REG_POOL, 2'b00}, 32'hFFFF_FFFF);
        random_phase(80, 32'hFFFF_FFFF);
        drain();

        // minimal pool
        reg_write({REG_POOL, 2'b00}, 32'd1);
        reg_write({REG_SLACK, 2'b00}, 32'd0);
        random_phase(40, 32'd1);
        drain();

        reg_write({REG_POOL, 2'b00}, 32'd1024);
        reg_write({REG_SLACK, 2'b00}, 32'd8);
        random_phase(90, 32'd1024);
        calm = 1'b1;
        random_phase(60, 32'd1024);
        drain();

        if (fail_count == 0)
            $display("first_fit_segment_allocator_tb: PASS");
        else
            $display("first_fit_segment_allocator_tb: FAIL");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("first_fit_segment_allocator_tb: FAIL");
        $finish;
    end
endmodule
